>>> rtl/tes_pkg.sv
// Shared types and constants for the time-tagged event scheduler.
`timescale 1ns / 1ps

package tes_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int TIME_W          = 32;
    localparam int CMD_W           = 16;
    localparam int POS_W           = 6;

    // action field codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] event_time;
        logic [CMD_W-1:0]  event_command;
        logic              load_last;
        logic [TIME_W-1:0] now_time;
    } t_in;

    typedef struct packed {
        logic              released;
        logic [CMD_W-1:0]  command_out;
        logic [POS_W-1:0]  release_position;
        logic              table_exhausted;
    } t_out;

    // one table row
    typedef struct packed {
        logic [TIME_W-1:0] time_code;
        logic [CMD_W-1:0]  command;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_WR,
        ST_TICK_CMP
    } t_state;

endpackage

>>> rtl/tes_table_ram.sv
// Event table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module tes_table_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tes_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output tes_pkg::t_entry o_rdata
);
    import tes_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tes_ctrl.sv
// Sequencer and shared time comparator: ordered insertion and tick release.
`timescale 1ns / 1ps

module tes_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_timing_enable,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tes_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    output tes_pkg::t_out   o_out_data,
    input  logic            i_out_stall,
    output logic            o_ram_we,
    output logic [AW-1:0]   o_ram_waddr,
    output tes_pkg::t_entry o_ram_wdata,
    output logic            o_ram_re,
    output logic [AW-1:0]   o_ram_raddr,
    input  tes_pkg::t_entry i_ram_rdata
);
    import tes_pkg::*;

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_key, n_key;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic              r_last, n_last;
    logic              r_elig, n_elig;
    logic [AW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_load_fill, n_load_fill;
    logic [CW-1:0]     r_entry_count, n_entry_count;
    logic [CW-1:0]     r_next_release, n_next_release;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              w_accept;
    logic              w_room;
    logic              w_gt;
    logic              w_out_free;
    logic              w_rel;
    logic [CW-1:0]     w_nr_after;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_room     = (r_load_fill < CW'(DEPTH));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // shared comparator: stored time code against the latched key
    assign w_gt = (i_ram_rdata.time_code > r_key);

    assign w_rel      = r_elig && !w_gt;
    assign w_nr_after = r_next_release + CW'(w_rel);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.action == ACT_TICK) begin
                        n_state = ST_TICK_CMP;
                    end else if (w_room) begin
                        n_state = (r_load_fill == '0) ? ST_INS_WR : ST_INS_CMP;
                    end
                end
            end
            ST_INS_CMP: begin
                if (!(w_gt && (r_pos != AW'(1)))) begin
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                n_state = ST_IDLE;
            end
            ST_TICK_CMP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath, memory control and result register
    always_comb begin
        n_key          = r_key;
        n_cmd          = r_cmd;
        n_last         = r_last;
        n_elig         = r_elig;
        n_pos          = r_pos;
        n_load_fill    = r_load_fill;
        n_entry_count  = r_entry_count;
        n_next_release = r_next_release;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out          = r_out;
        o_ram_we       = 1'b0;
        o_ram_waddr    = r_pos;
        o_ram_wdata    = '{time_code: r_key, command: r_cmd};
        o_ram_re       = 1'b0;
        o_ram_raddr    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_in_data.event_command;
                    n_last = i_in_data.load_last;
                    if (i_in_data.action == ACT_TICK) begin
                        // fetch the next unreleased entry
                        n_key       = i_in_data.now_time;
                        n_elig      = i_timing_enable && (r_next_release < r_entry_count);
                        o_ram_re    = 1'b1;
                        o_ram_raddr = AW'(r_next_release);
                    end else begin
                        n_key = i_in_data.event_time;
                        // first entry of a new table retires the old one
                        if (r_load_fill == '0) begin
                            n_entry_count  = '0;
                            n_next_release = '0;
                        end
                        if (w_room) begin
                            n_pos = AW'(r_load_fill);
                            if (r_load_fill != '0) begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = AW'(r_load_fill - CW'(1));
                            end
                        end else if (i_in_data.load_last) begin
                            // table full: entry dropped, load still completes
                            n_entry_count  = r_load_fill;
                            n_next_release = '0;
                            n_load_fill    = '0;
                        end
                    end
                end
            end
            ST_INS_CMP: begin
                // later entry moves up one slot, prefetch the one below
                if (w_gt) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_pos;
                    o_ram_wdata = i_ram_rdata;
                    n_pos       = r_pos - AW'(1);
                    if (r_pos != AW'(1)) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_pos - AW'(2);
                    end
                end
            end
            ST_INS_WR: begin
                o_ram_we    = 1'b1;
                n_load_fill = r_load_fill + CW'(1);
                if (r_last) begin
                    n_entry_count  = r_load_fill + CW'(1);
                    n_next_release = '0;
                    n_load_fill    = '0;
                end
            end
            ST_TICK_CMP: begin
                if (w_out_free) begin
                    n_out_valid                = 1'b1;
                    n_out.released             = w_rel;
                    n_out.command_out          = w_rel ? i_ram_rdata.command : '0;
                    n_out.release_position     = w_rel ? POS_W'(r_next_release) : '0;
                    n_out.table_exhausted      = (w_nr_after >= r_entry_count);
                    n_next_release             = w_nr_after;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_load_fill    <= '0;
            r_entry_count  <= '0;
            r_next_release <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_load_fill    <= n_load_fill;
            r_entry_count  <= n_entry_count;
            r_next_release <= n_next_release;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_cmd  <= n_cmd;
        r_last <= n_last;
        r_elig <= n_elig;
        r_pos  <= n_pos;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/time_tagged_event_scheduler.sv
// Top level of the time-tagged event scheduler.
`timescale 1ns / 1ps

// Time-tagged event scheduler.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): a load transaction
// writes one event (time code, command); the load marked load_last closes the
// table and rewinds the release pointer. A tick transaction carries now_time and
// returns exactly one result transaction; loads return none.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): released flag,
// command, sorted position and table-exhausted flag.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): timing_enable, always
// ready. The user must write it only while the block is idle; the block itself does not enforce this.
// Each load is placed in time order by insertion. After acceptance o_in_stall
// stays high through ST_INS_WR for the first entry of a table; otherwise ST_INS_CMP
// first moves each stored entry with a later time code up one slot, through the
// shared comparator and the memory's one write and one read port, then ST_INS_WR
// writes the event. A load dropped on a full table does not raise o_in_stall.
// A tick reads the next entry as it is accepted and compares in the next cycle,
// in ST_TICK_CMP; the result is loaded into the output register once that register is free.
// One transaction is in work at a time; o_in_stall is high until it finishes.
// A new transaction is taken while a result still waits in the output register;
// a tick completes only once that register is free, so a stalled receiver
// holds the block at that point. Reset clears the table state (empty table,
// timing disabled); the memory needs no clearing pass.
module time_tagged_event_scheduler #(
    parameter int TABLE_DEPTH = tes_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tes_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tes_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);
    import tes_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic          r_timing_enable;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    t_entry        w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    t_entry        w_ram_rdata;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timing_enable <= i_cfg_data;
        end
    end

    tes_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timing_enable (r_timing_enable),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_data       (i_in_data),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data),
        .i_out_stall     (i_out_stall),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_re        (w_ram_re),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata)
    );

    tes_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // an accepted tick always keeps the block busy for its compare step
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.action == ACT_TICK)) |=> o_in_stall)
        else $error("tick accepted without entering the compare step");

    // a new result only comes out of a tick in work
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a tick in work");

    // a result without a release carries no command and no position
    a_no_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.released) |->
            ((o_out_data.command_out == '0) && (o_out_data.release_position == '0)))
        else $error("non-release result carries command or position");

endmodule
